### rtl/dns_reply_address_extractor_defines.svh
// Assertion macros shared by the checker of the DNS reply address extractor.
`ifndef DNS_REPLY_ADDRESS_EXTRACTOR_DEFINES_SVH
`define DNS_REPLY_ADDRESS_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DRE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dre assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dre assertion failed");

// Next-cycle implication that is also checked through reset.
`define DRE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dre assertion failed");

`endif

### rtl/dre_pkg.sv
// Types, constants and helpers for the DNS reply address extractor.
`default_nettype none

package dre_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QLEN   = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QTAIL  = 4'd3,
    PH_AFIRST = 4'd4,
    PH_ALEN   = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_FIXED  = 4'd8,
    PH_RDATA  = 4'd9,
    PH_DONE   = 4'd10
  } phase_t;

  localparam logic [15:0] HeaderBytes = 16'd12;
  localparam logic [15:0] FixedBytes  = 16'd10;
  localparam logic [15:0] QTailBytes  = 16'd4;
  localparam logic [15:0] PosMax      = 16'hFFFF;
  localparam logic [7:0]  PointerMask = 8'hC0;

  // Offsets of the interesting bytes inside the fixed answer fields.
  localparam logic [3:0] OffTypeHi  = 4'd0;
  localparam logic [3:0] OffTypeLo  = 4'd1;
  localparam logic [3:0] OffClassHi = 4'd2;
  localparam logic [3:0] OffClassLo = 4'd3;
  localparam logic [3:0] OffLenHi   = 4'd8;
  localparam logic [3:0] OffLenLo   = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] reply_id;
    logic [31:0] ipv4_address;
  } result_t;

  function automatic logic is_a_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                       input logic [15:0] rlen);
    return (rtype == 16'd1) && (rclass == 16'd1) && (rlen == 16'd4);
  endfunction

endpackage

`default_nettype wire

### rtl/dre_in_stage.sv
// Input register that holds one reply byte until the parser takes it.
`default_nettype none

module dre_in_stage (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire dre_pkg::byte_word_t in_word,
  input  wire                      take,
  output logic                     held_valid,
  output dre_pkg::byte_word_t      held_word
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_word <= in_word;
    end
  end

endmodule

`default_nettype wire

### rtl/dre_parser.sv
// Parse state of the DNS reply and the result that the current byte would give.
`default_nettype none

module dre_parser (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      take,
  input  wire dre_pkg::byte_word_t word,
  output dre_pkg::result_t         res
);

  dre_pkg::phase_t phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] skip, skip_next;
  logic [15:0] id_reg, id_next;
  logic [15:0] rtype, rtype_next;
  logic [15:0] rclass, rclass_next;
  logic [15:0] rlen, rlen_next;
  logic [31:0] addr, addr_next;
  logic        err, err_next;
  logic        found, found_next;

  logic [7:0]  b;
  logic [15:0] pos_inc;
  logic [15:0] skip_dec;
  logic [3:0]  off;
  logic        hdr_fail;
  logic        ok;

  assign b        = word.data_byte;
  assign pos_inc  = pos + 16'd1;
  assign skip_dec = skip - 16'd1;
  assign off      = 4'(dre_pkg::FixedBytes - skip);

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    skip_next   = skip;
    id_next     = id_reg;
    rtype_next  = rtype;
    rclass_next = rclass;
    rlen_next   = rlen;
    addr_next   = addr;
    err_next    = err;
    found_next  = found;
    hdr_fail    = 1'b0;

    if (pos == dre_pkg::PosMax) begin
      // The position counter has saturated: the reply is too long.
      err_next   = 1'b1;
      phase_next = dre_pkg::PH_DONE;
    end else begin
      pos_next = pos_inc;
      case (phase)
        dre_pkg::PH_HEADER: begin
          if (pos == 16'd0) begin
            id_next = {b, 8'h00};
          end else if (pos == 16'd1) begin
            id_next = id_reg | {8'h00, b};
          end else if ((pos == 16'd4 || pos == 16'd6) && b != 8'd0) begin
            hdr_fail = 1'b1;
          end else if ((pos == 16'd5 || pos == 16'd7) && b != 8'd1) begin
            hdr_fail = 1'b1;
          end
          if (hdr_fail) begin
            err_next   = 1'b1;
            phase_next = dre_pkg::PH_DONE;
          end else if (pos_inc >= dre_pkg::HeaderBytes) begin
            phase_next = dre_pkg::PH_QLEN;
          end
        end
        dre_pkg::PH_QLEN: begin
          if (b == 8'd0) begin
            skip_next  = dre_pkg::QTailBytes;
            phase_next = dre_pkg::PH_QTAIL;
          end else begin
            skip_next  = {8'h00, b};
            phase_next = dre_pkg::PH_QLABEL;
          end
        end
        dre_pkg::PH_QLABEL: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) phase_next = dre_pkg::PH_QLEN;
        end
        dre_pkg::PH_QTAIL: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) phase_next = dre_pkg::PH_AFIRST;
        end
        dre_pkg::PH_AFIRST, dre_pkg::PH_ALEN: begin
          // Only the first byte of the answer name may be a compression pointer.
          if (phase == dre_pkg::PH_AFIRST &&
              (b & dre_pkg::PointerMask) == dre_pkg::PointerMask) begin
            phase_next = dre_pkg::PH_APTR;
          end else if (b == 8'd0) begin
            skip_next  = dre_pkg::FixedBytes;
            phase_next = dre_pkg::PH_FIXED;
          end else begin
            skip_next  = {8'h00, b};
            phase_next = dre_pkg::PH_ALABEL;
          end
        end
        dre_pkg::PH_ALABEL: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) phase_next = dre_pkg::PH_ALEN;
        end
        dre_pkg::PH_APTR: begin
          skip_next  = dre_pkg::FixedBytes;
          phase_next = dre_pkg::PH_FIXED;
        end
        dre_pkg::PH_FIXED: begin
          case (off)
            dre_pkg::OffTypeHi:  rtype_next  = {b, 8'h00};
            dre_pkg::OffTypeLo:  rtype_next  = rtype | {8'h00, b};
            dre_pkg::OffClassHi: rclass_next = {b, 8'h00};
            dre_pkg::OffClassLo: rclass_next = rclass | {8'h00, b};
            dre_pkg::OffLenHi:   rlen_next   = {b, 8'h00};
            dre_pkg::OffLenLo:   rlen_next   = rlen | {8'h00, b};
            default: ;
          endcase
          skip_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (rlen_next == 16'd0) begin
              if (dre_pkg::is_a_record(rtype_next, rclass_next, rlen_next)) begin
                found_next = 1'b1;
              end else begin
                err_next = 1'b1;
              end
              phase_next = dre_pkg::PH_DONE;
            end else begin
              skip_next  = rlen_next;
              phase_next = dre_pkg::PH_RDATA;
            end
          end
        end
        dre_pkg::PH_RDATA: begin
          if (dre_pkg::is_a_record(rtype, rclass, rlen)) begin
            addr_next = {addr[23:0], b};
          end
          skip_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (dre_pkg::is_a_record(rtype, rclass, rlen)) begin
              found_next = 1'b1;
            end else begin
              err_next = 1'b1;
            end
            phase_next = dre_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign ok               = found_next && !err_next;
  assign res.status       = !ok;
  assign res.reply_id     = (pos_next < dre_pkg::HeaderBytes) ? 16'd0 : id_next;
  assign res.ipv4_address = ok ? addr_next : 32'd0;

  // After the last word of a reply all parse state returns to its start value.
  always_ff @(posedge clk) begin
    if (rst || (take && word.last_byte)) begin
      phase  <= dre_pkg::PH_HEADER;
      pos    <= 16'd0;
      skip   <= 16'd0;
      id_reg <= 16'd0;
      rtype  <= 16'd0;
      rclass <= 16'd0;
      rlen   <= 16'd0;
      addr   <= 32'd0;
      err    <= 1'b0;
      found  <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      pos    <= pos_next;
      skip   <= skip_next;
      id_reg <= id_next;
      rtype  <= rtype_next;
      rclass <= rclass_next;
      rlen   <= rlen_next;
      addr   <= addr_next;
      err    <= err_next;
      found  <= found_next;
    end
  end

endmodule

`default_nettype wire

### rtl/dre_out_stage.sv
// Result register that holds one finished result until it is taken.
`default_nettype none

module dre_out_stage (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   load,
  input  wire dre_pkg::result_t res,
  output logic                  free,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  status,
  output logic [15:0]           reply_id,
  output logic [31:0]           ipv4_address
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status       <= res.status;
      reply_id     <= res.reply_id;
      ipv4_address <= res.ipv4_address;
    end
  end

endmodule

`default_nettype wire

### rtl/dns_reply_address_extractor.sv
// DNS reply address extractor: streams a reply and returns its id and A-record address.
// Reply bytes enter one word per cycle; a word is accepted every cycle as long as the
// result register is not holding an untaken result when a last word must be finished.
// Each word is parsed while it sits in the input register; the result register loads
// when the last word of a reply is taken from there, which waits while the result
// register holds an untaken result. Only the last word of a reply produces a result;
// status 0 means an IPv4 A record was found.
`default_nettype none

module dns_reply_address_extractor (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        status,
  output logic [15:0] reply_id,
  output logic [31:0] ipv4_address
);

  dre_pkg::byte_word_t in_word;
  dre_pkg::byte_word_t held_word;
  dre_pkg::result_t    res;
  logic                held_valid;
  logic                out_free;
  logic                take;

  assign in_word.data_byte = data_byte;
  assign in_word.last_byte = last_byte;

  // A last word waits in the input register until the result register is free.
  assign take = held_valid && (!held_word.last_byte || out_free);

  dre_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .take      (take),
    .held_valid(held_valid),
    .held_word (held_word)
  );

  dre_parser u_parser (
    .clk (clk),
    .rst (rst),
    .take(take),
    .word(held_word),
    .res (res)
  );

  dre_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (take && held_word.last_byte),
    .res         (res),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .reply_id    (reply_id),
    .ipv4_address(ipv4_address)
  );

endmodule

`default_nettype wire

### rtl/dre_checker.sv
// Port-level checks for the DNS reply address extractor and their binding.
`default_nettype none
`include "dns_reply_address_extractor_defines.svh"

module dre_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        status,
  input wire [15:0] reply_id,
  input wire [31:0] ipv4_address
);

  // A stalled result keeps its word.
  `DRE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(reply_id) && $stable(ipv4_address))

  // Reset empties the result register.
  `DRE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // A failed reply never carries an address.
  `DRE_ASSERT_IMPL(a_err_no_addr, clk, rst, out_valid && status, ipv4_address == 32'd0)

  // With no result waiting the input side never stalls.
  `DRE_ASSERT_IMPL(a_ready_when_empty, clk, rst, !out_valid, in_ready)

endmodule

bind dns_reply_address_extractor dre_checker u_dre_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .reply_id    (reply_id),
  .ipv4_address(ipv4_address)
);

`default_nettype wire
